// ===== sv/bnd_pkg.sv =====
// ----------------------------------------------------------------------------
// bnd_pkg
// Shared widths, codes and types of the bounded note dispenser.
// ----------------------------------------------------------------------------
package bnd_pkg;

    localparam int AMT_W     = 20;
    localparam int VAL_W     = 16;
    localparam int CNT_W     = 12;
    localparam int MAX_RES   = 8;
    localparam int SLOTS_DEF = 8;
    localparam int FEW_W     = 16;

    localparam logic [FEW_W-1:0] NO_WAY = '1;

    localparam logic [1:0] OP_LOAD   = 2'd0;
    localparam logic [1:0] OP_GREEDY = 2'd1;
    localparam logic [1:0] OP_FEWEST = 2'd2;

    localparam logic [1:0] ST_DISPENSED = 2'd0;
    localparam logic [1:0] ST_NO_WAY    = 2'd1;
    localparam logic [1:0] ST_LOADED    = 2'd2;

    typedef struct packed {
        logic             en;
        logic [AMT_W-1:0] addr;
        logic [FEW_W-1:0] data;
    } tbl_wr_t;

endpackage

// ===== sv/bnd_div.sv =====
// ----------------------------------------------------------------------------
// bnd_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module bnd_div
    import bnd_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [AMT_W-1:0] dividend,
    input  logic [VAL_W-1:0] divisor,
    output logic             done,
    output logic [AMT_W-1:0] quotient
);

    localparam int STEP_W = $clog2(AMT_W);

    logic              busy_reg;
    logic              done_reg;
    logic [STEP_W-1:0] cnt_reg;
    logic [VAL_W:0]    r_reg;
    logic [AMT_W-1:0]  q_reg;
    logic [VAL_W-1:0]  d_reg;
    logic [VAL_W:0]    r_sh;
    logic [VAL_W:0]    diff;
    logic              ge;

    always_comb begin
        r_sh = {r_reg[VAL_W-1:0], q_reg[AMT_W-1]};
        ge   = r_sh >= {1'b0, d_reg};
        diff = r_sh - {1'b0, d_reg};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
                r_reg    <= '0;
                q_reg    <= dividend;
                d_reg    <= divisor;
            end else if (busy_reg) begin
                r_reg   <= ge ? diff : r_sh;
                q_reg   <= {q_reg[AMT_W-2:0], ge};
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == STEP_W'(AMT_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done     = done_reg;
    assign quotient = q_reg;

endmodule

// ===== sv/bnd_tbl.sv =====
// ----------------------------------------------------------------------------
// bnd_tbl
// Fewest-notes table: one write port, two registered read ports.
// ----------------------------------------------------------------------------
module bnd_tbl
    import bnd_pkg::*;
(
    input  logic             aclk,
    input  tbl_wr_t          wr,
    input  logic [AMT_W-1:0] rd_a_addr,
    input  logic [AMT_W-1:0] rd_b_addr,
    output logic [FEW_W-1:0] rd_a_data,
    output logic [FEW_W-1:0] rd_b_data
);

    logic [FEW_W-1:0] mem [2**AMT_W];

    always_ff @(posedge aclk) begin
        if (wr.en) begin
            mem[wr.addr] <= wr.data;
        end
        rd_a_data <= mem[rd_a_addr];
        rd_b_data <= mem[rd_b_addr];
    end

endmodule

// ===== sv/bounded_note_dispenser.sv =====
// A load presents its item in the cycle after acceptance; withdraw results follow the search.
// Greedy withdraw: for each slot in use, a divide, a multiply and a subtract (skipped for a zero note value).
// Fewest-notes withdraw: each table build clears entries 0 to its limit, then runs over the table
// per binary piece of each slot count; n+1 builds, then a table read per candidate use.
// One item at a time; s_ready is high only when no item is in work or awaiting delivery.
// Reset (aresetn, synchronous): values all ones, counts zero, slots_in_use 1; no clearing pass.
// ----------------------------------------------------------------------------
// bounded_note_dispenser
// Note dispenser with greedy and fewest-notes withdrawal over loaded slots.
// ----------------------------------------------------------------------------
module bounded_note_dispenser
    import bnd_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEF
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  logic [1:0]       s_op,
    input  logic [2:0]       s_slot,
    input  logic [15:0]      s_note_value,
    input  logic [11:0]      s_note_count,
    input  logic [19:0]      s_amount,
    output logic             m_valid,
    input  logic             m_ready,
    output logic [2:0]       m_out_slot,
    output logic [11:0]      m_notes_taken,
    output logic [1:0]       m_status,
    output logic             m_last,
    input  logic             psel,
    input  logic             penable,
    input  logic             pwrite,
    input  logic [2:0]       paddr,
    input  logic [31:0]      pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CAP   = (SLOTS < MAX_RES) ? SLOTS : MAX_RES;
    localparam int K_W   = 4;

    localparam logic [4:0] S_IDLE    = 5'd0;
    localparam logic [4:0] S_G_DIV   = 5'd1;
    localparam logic [4:0] S_G_WAIT  = 5'd2;
    localparam logic [4:0] S_G_MUL   = 5'd3;
    localparam logic [4:0] S_G_SUB   = 5'd4;
    localparam logic [4:0] S_CLR     = 5'd5;
    localparam logic [4:0] S_B_SLOT  = 5'd6;
    localparam logic [4:0] S_P_PIECE = 5'd7;
    localparam logic [4:0] S_P_CHK   = 5'd8;
    localparam logic [4:0] S_P_RUN   = 5'd9;
    localparam logic [4:0] S_P_FLUSH = 5'd10;
    localparam logic [4:0] S_P_NEXT  = 5'd11;
    localparam logic [4:0] S_F_GOAL  = 5'd12;
    localparam logic [4:0] S_F_GOAL2 = 5'd13;
    localparam logic [4:0] S_F_NEXTK = 5'd14;
    localparam logic [4:0] S_F_SCAN  = 5'd15;
    localparam logic [4:0] S_F_RD    = 5'd16;
    localparam logic [4:0] S_F_CHK   = 5'd17;
    localparam logic [4:0] S_COMMIT  = 5'd18;
    localparam logic [4:0] S_OUT     = 5'd19;

    logic [4:0]       state_reg;
    logic [3:0]       siu_reg;
    logic [VAL_W-1:0] values_reg [SLOTS];
    logic [CNT_W-1:0] counts_reg [SLOTS];
    logic [CNT_W-1:0] take_reg [MAX_RES];
    logic             ok_reg;
    logic             load_reg;
    logic [2:0]       lslot_reg;
    logic [AMT_W-1:0] amount_reg;
    logic [AMT_W-1:0] rem_reg;
    logic [K_W-1:0]   k_reg;
    logic [CNT_W-1:0] t_reg;
    logic [27:0]      prod_reg;
    logic [AMT_W-1:0] limit_reg;
    logic [AMT_W-1:0] clr_reg;
    logic [K_W-1:0]   from_reg;
    logic [K_W-1:0]   s_reg;
    logic             phase_reg;
    logic [VAL_W-1:0] cv_reg;
    logic [CNT_W-1:0] remc_reg;
    logic [CNT_W:0]   m_reg;
    logic [CNT_W-1:0] piece_reg;
    logic [AMT_W-1:0] r_reg;
    logic [AMT_W-1:0] w_reg;
    logic             pend_reg;
    logic [AMT_W-1:0] pend_addr_reg;
    logic [FEW_W-1:0] goal_reg;
    logic [CNT_W-1:0] j_reg;
    logic [AMT_W-1:0] idx_reg;

    logic [K_W-1:0]   n_act;
    logic [VAL_W-1:0] kv;
    logic [CNT_W-1:0] kc;
    logic [K_W-1:0]   sel;
    logic [VAL_W-1:0] sv;
    logic [CNT_W-1:0] sc;
    logic [CNT_W-1:0] piece;
    logic             div_start;
    logic             div_done;
    logic [AMT_W-1:0] div_q;
    tbl_wr_t          tw;
    logic [AMT_W-1:0] rd_a_addr;
    logic [FEW_W-1:0] rd_a;
    logic [FEW_W-1:0] rd_b;
    logic [FEW_W:0]   cand;
    logic [FEW_W:0]   gsum;
    logic             match;
    logic             s_acc;
    logic             p_wr;

    always_comb begin
        if (siu_reg == 4'd0) begin
            n_act = 4'd1;
        end else if (32'(siu_reg) > CAP) begin
            n_act = K_W'(CAP);
        end else begin
            n_act = siu_reg;
        end
        kv    = values_reg[k_reg[IDX_W-1:0]];
        kc    = counts_reg[k_reg[IDX_W-1:0]];
        sel   = s_reg - 1'b1;
        sv    = values_reg[sel[IDX_W-1:0]];
        sc    = counts_reg[sel[IDX_W-1:0]];
        piece = ({1'b0, remc_reg} < m_reg) ? remc_reg : m_reg[CNT_W-1:0];
        cand  = {1'b0, rd_b} + {{(FEW_W-CNT_W+1){1'b0}}, piece_reg};
        gsum  = {1'b0, rd_a} + {{(FEW_W-CNT_W+1){1'b0}}, j_reg};
        match = (rd_a != NO_WAY) && (gsum == {1'b0, goal_reg});
        s_acc = s_valid && s_ready;
        p_wr  = psel && penable && pwrite && pready;
    end

    assign s_ready   = (state_reg == S_IDLE);
    assign div_start = (state_reg == S_G_DIV) && (k_reg != n_act) && (kv != '0);
    assign rd_a_addr = (state_reg == S_P_RUN)  ? r_reg :
                       (state_reg == S_F_GOAL) ? amount_reg : idx_reg;

    always_comb begin
        tw = '0;
        if (state_reg == S_CLR) begin
            tw.en   = 1'b1;
            tw.addr = clr_reg;
            tw.data = (clr_reg == '0) ? '0 : NO_WAY;
        end else if (pend_reg) begin
            tw.en   = 1'b1;
            tw.addr = pend_addr_reg;
            tw.data = (rd_b != NO_WAY && cand < {1'b0, rd_a}) ? cand[FEW_W-1:0] : rd_a;
        end
    end

    bnd_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (rem_reg),
        .divisor  (kv),
        .done     (div_done),
        .quotient (div_q)
    );

    bnd_tbl u_tbl (
        .aclk      (aclk),
        .wr        (tw),
        .rd_a_addr (rd_a_addr),
        .rd_b_addr (r_reg - w_reg),
        .rd_a_data (rd_a),
        .rd_b_data (rd_b)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            siu_reg <= 4'd1;
        end else if (p_wr && paddr == '0) begin
            siu_reg <= pwdata[3:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr == '0) ? {28'd0, siu_reg} : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            pend_reg  <= 1'b0;
            for (int i = 0; i < SLOTS; i++) begin
                values_reg[i] <= '1;
                counts_reg[i] <= '0;
            end
        end else begin
            pend_reg <= 1'b0;
            case (state_reg)
                S_IDLE: begin
                    if (s_acc) begin
                        lslot_reg  <= s_slot;
                        amount_reg <= s_amount;
                        rem_reg    <= s_amount;
                        k_reg      <= '0;
                        load_reg   <= 1'b0;
                        case (s_op)
                            OP_LOAD: begin
                                if (32'(s_slot) < SLOTS) begin
                                    values_reg[s_slot[IDX_W-1:0]] <= s_note_value;
                                    counts_reg[s_slot[IDX_W-1:0]] <= s_note_count;
                                end
                                load_reg  <= 1'b1;
                                state_reg <= S_OUT;
                            end
                            OP_GREEDY: state_reg <= S_G_DIV;
                            OP_FEWEST: begin
                                from_reg  <= '0;
                                limit_reg <= s_amount;
                                phase_reg <= 1'b0;
                                clr_reg   <= '0;
                                state_reg <= S_CLR;
                            end
                            default: state_reg <= S_IDLE;
                        endcase
                    end
                end
                S_G_DIV: begin
                    if (k_reg == n_act) begin
                        ok_reg    <= (rem_reg == '0);
                        state_reg <= S_COMMIT;
                    end else if (kv == '0) begin
                        take_reg[k_reg[2:0]] <= '0;
                        k_reg <= k_reg + 1'b1;
                    end else begin
                        state_reg <= S_G_WAIT;
                    end
                end
                S_G_WAIT: begin
                    if (div_done) begin
                        t_reg     <= (div_q > AMT_W'(kc)) ? kc : div_q[CNT_W-1:0];
                        state_reg <= S_G_MUL;
                    end
                end
                S_G_MUL: begin
                    take_reg[k_reg[2:0]] <= t_reg;
                    prod_reg  <= 28'(t_reg) * 28'(kv);
                    state_reg <= S_G_SUB;
                end
                S_G_SUB: begin
                    rem_reg   <= rem_reg - prod_reg[AMT_W-1:0];
                    k_reg     <= k_reg + 1'b1;
                    state_reg <= S_G_DIV;
                end
                S_CLR: begin
                    if (clr_reg == limit_reg) begin
                        s_reg     <= n_act;
                        state_reg <= S_B_SLOT;
                    end else begin
                        clr_reg <= clr_reg + 1'b1;
                    end
                end
                S_B_SLOT: begin
                    if (s_reg == from_reg) begin
                        state_reg <= phase_reg ? S_F_SCAN : S_F_GOAL;
                    end else begin
                        s_reg <= sel;
                        if (sv != '0 && sc != '0) begin
                            cv_reg    <= sv;
                            remc_reg  <= sc;
                            m_reg     <= (CNT_W+1)'(1);
                            state_reg <= S_P_PIECE;
                        end
                    end
                end
                S_P_PIECE: begin
                    piece_reg <= piece;
                    prod_reg  <= 28'(piece) * 28'(cv_reg);
                    state_reg <= S_P_CHK;
                end
                S_P_CHK: begin
                    if (prod_reg > 28'(limit_reg)) begin
                        state_reg <= S_P_NEXT;
                    end else begin
                        r_reg     <= limit_reg;
                        w_reg     <= prod_reg[AMT_W-1:0];
                        state_reg <= S_P_RUN;
                    end
                end
                S_P_RUN: begin
                    pend_reg      <= 1'b1;
                    pend_addr_reg <= r_reg;
                    if (r_reg == w_reg) begin
                        state_reg <= S_P_FLUSH;
                    end else begin
                        r_reg <= r_reg - 1'b1;
                    end
                end
                S_P_FLUSH: state_reg <= S_P_NEXT;
                S_P_NEXT: begin
                    remc_reg <= remc_reg - piece_reg;
                    m_reg    <= {m_reg[CNT_W-1:0], 1'b0};
                    state_reg <= (remc_reg == piece_reg) ? S_B_SLOT : S_P_PIECE;
                end
                S_F_GOAL: state_reg <= S_F_GOAL2;
                S_F_GOAL2: begin
                    if (rd_a == NO_WAY) begin
                        ok_reg    <= 1'b0;
                        state_reg <= S_COMMIT;
                    end else begin
                        goal_reg  <= rd_a;
                        rem_reg   <= amount_reg;
                        k_reg     <= '0;
                        state_reg <= S_F_NEXTK;
                    end
                end
                S_F_NEXTK: begin
                    if (k_reg == n_act) begin
                        ok_reg    <= 1'b1;
                        state_reg <= S_COMMIT;
                    end else begin
                        from_reg  <= k_reg + 1'b1;
                        limit_reg <= rem_reg;
                        phase_reg <= 1'b1;
                        clr_reg   <= '0;
                        state_reg <= S_CLR;
                    end
                end
                S_F_SCAN: begin
                    j_reg     <= '0;
                    idx_reg   <= rem_reg;
                    state_reg <= S_F_RD;
                end
                S_F_RD: state_reg <= S_F_CHK;
                S_F_CHK: begin
                    if (match) begin
                        take_reg[k_reg[2:0]] <= j_reg;
                        rem_reg   <= idx_reg;
                        goal_reg  <= goal_reg - FEW_W'(j_reg);
                        k_reg     <= k_reg + 1'b1;
                        state_reg <= S_F_NEXTK;
                    end else if (kv != '0 && j_reg < kc && idx_reg >= AMT_W'(kv)) begin
                        j_reg     <= j_reg + 1'b1;
                        idx_reg   <= idx_reg - AMT_W'(kv);
                        state_reg <= S_F_RD;
                    end else begin
                        take_reg[k_reg[2:0]] <= '0;
                        k_reg     <= k_reg + 1'b1;
                        state_reg <= S_F_NEXTK;
                    end
                end
                S_COMMIT: begin
                    for (int i = 0; i < SLOTS; i++) begin
                        if (i < MAX_RES && ok_reg && K_W'(i) < n_act) begin
                            counts_reg[i] <= counts_reg[i] - take_reg[i % MAX_RES];
                        end
                    end
                    k_reg     <= '0;
                    state_reg <= S_OUT;
                end
                S_OUT: begin
                    if (m_ready) begin
                        if (load_reg || k_reg == n_act - 1'b1) begin
                            state_reg <= S_IDLE;
                        end else begin
                            k_reg <= k_reg + 1'b1;
                        end
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign m_valid       = (state_reg == S_OUT);
    assign m_out_slot    = load_reg ? lslot_reg : k_reg[2:0];
    assign m_notes_taken = (load_reg || !ok_reg) ? '0 : take_reg[k_reg[2:0]];
    assign m_status      = load_reg ? ST_LOADED : (ok_reg ? ST_DISPENSED : ST_NO_WAY);
    assign m_last        = load_reg || (k_reg == n_act - 1'b1);

`ifndef SYNTHESIS
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !s_ready) else $error("result pending while accepting");
    a_wr_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        tw.en |-> tw.addr <= limit_reg) else $error("table write beyond limit");
    a_out_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !load_reg) |-> k_reg < n_act) else $error("result slot out of range");
    a_div_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> state_reg == S_G_WAIT) else $error("quotient arrived unexpectedly");
`endif

endmodule
